### hw/rtl/jdma_pkg.sv
package jdma_pkg;

	// Field and configuration widths
	localparam int AXIS_W     = 10;
	localparam int STICK_W    = 1;
	localparam int WIN_REG_W  = 5;
	localparam int DATA_W     = 24;
	localparam int CFG_DATA_W = 32;
	localparam int PADDR_W    = 5;
	localparam int REG_IDX_W  = 3;

	// Sizing of the filter state
	localparam int STICKS     = 2;
	localparam int WINDOW_MAX = 16;
	localparam int AXIS_TOP   = (1 << AXIS_W) - 1;
	localparam int SUM_W      = $clog2(WINDOW_MAX * AXIS_TOP + 1);
	localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
	localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int RING_DEPTH = STICKS * WINDOW_MAX;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SQ_W       = 2 * AXIS_W;
	localparam int CNT_W      = $clog2(SUM_W);

	localparam logic [AXIS_W-1:0] AXIS_MAX = AXIS_W'(AXIS_TOP);

	// Register indexes (byte address / 4)
	localparam logic [REG_IDX_W-1:0] REG_REST_X_FIRST  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_REST_Y_FIRST  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REST_X_SECOND = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REST_Y_SECOND = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DEADBAND      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW        = 3'd5;

	// Register reset values
	localparam logic [AXIS_W-1:0]    REST_RESET   = 10'd512;
	localparam logic [AXIS_W-1:0]    RADIUS_RESET = 10'd25;
	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 5'd16;

	typedef struct packed {
		logic [AXIS_W-1:0]    rest_x_first;
		logic [AXIS_W-1:0]    rest_y_first;
		logic [AXIS_W-1:0]    rest_x_second;
		logic [AXIS_W-1:0]    rest_y_second;
		logic [AXIS_W-1:0]    deadband_radius;
		logic [WIN_REG_W-1:0] window_length;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture the input item
		logic square;    // form squared offsets, read the ring slot
		logic judge;     // register the deadband decision
		logic update;    // write ring, sums, position; load dividers
		logic div_step;  // one quotient bit per axis
		logic out_load;  // fill the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;
	} sts_t;

endpackage

### hw/rtl/jdma_regs.sv
module jdma_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [jdma_pkg::PADDR_W-1:0]      paddr,
	input  logic [jdma_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [jdma_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output jdma_pkg::cfg_t                    cfg
);

	jdma_pkg::cfg_t                   cfg_q;
	logic [jdma_pkg::REG_IDX_W-1:0]   idx;
	logic                             wr_en;

	assign idx    = paddr[jdma_pkg::PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_x_first    <= jdma_pkg::REST_RESET;
			cfg_q.rest_y_first    <= jdma_pkg::REST_RESET;
			cfg_q.rest_x_second   <= jdma_pkg::REST_RESET;
			cfg_q.rest_y_second   <= jdma_pkg::REST_RESET;
			cfg_q.deadband_radius <= jdma_pkg::RADIUS_RESET;
			cfg_q.window_length   <= jdma_pkg::WINDOW_RESET;
		end else if (wr_en) begin
			case (idx)
				jdma_pkg::REG_REST_X_FIRST:
					cfg_q.rest_x_first <= pwdata[jdma_pkg::AXIS_W-1:0];
				jdma_pkg::REG_REST_Y_FIRST:
					cfg_q.rest_y_first <= pwdata[jdma_pkg::AXIS_W-1:0];
				jdma_pkg::REG_REST_X_SECOND:
					cfg_q.rest_x_second <= pwdata[jdma_pkg::AXIS_W-1:0];
				jdma_pkg::REG_REST_Y_SECOND:
					cfg_q.rest_y_second <= pwdata[jdma_pkg::AXIS_W-1:0];
				jdma_pkg::REG_DEADBAND:
					cfg_q.deadband_radius <= pwdata[jdma_pkg::AXIS_W-1:0];
				jdma_pkg::REG_WINDOW:
					cfg_q.window_length <= pwdata[jdma_pkg::WIN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (idx)
			jdma_pkg::REG_REST_X_FIRST:  prdata = jdma_pkg::CFG_DATA_W'(cfg_q.rest_x_first);
			jdma_pkg::REG_REST_Y_FIRST:  prdata = jdma_pkg::CFG_DATA_W'(cfg_q.rest_y_first);
			jdma_pkg::REG_REST_X_SECOND: prdata = jdma_pkg::CFG_DATA_W'(cfg_q.rest_x_second);
			jdma_pkg::REG_REST_Y_SECOND: prdata = jdma_pkg::CFG_DATA_W'(cfg_q.rest_y_second);
			jdma_pkg::REG_DEADBAND:      prdata = jdma_pkg::CFG_DATA_W'(cfg_q.deadband_radius);
			jdma_pkg::REG_WINDOW:        prdata = jdma_pkg::CFG_DATA_W'(cfg_q.window_length);
			default:                     prdata = '0;
		endcase
	end

endmodule

### hw/rtl/jdma_ctrl.sv
module jdma_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output jdma_pkg::cmd_t cmd,
	input  jdma_pkg::sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQUARE = 3'd1;
	localparam logic [2:0] ST_JUDGE  = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_DIVIDE = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	localparam logic [jdma_pkg::CNT_W-1:0] CNT_LAST = jdma_pkg::CNT_W'(jdma_pkg::SUM_W - 1);

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [jdma_pkg::CNT_W-1:0] cnt_q;
	logic                       m_tvalid_q;
	logic                       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_JUDGE;
			end
			ST_JUDGE: begin
				cmd.judge = 1'b1;
				state_d   = sts.hit ? ST_UPDATE : ST_FINISH;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/jdma_dp.sv
module jdma_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jdma_pkg::cfg_t                  cfg,
	input  jdma_pkg::cmd_t                  cmd,
	output jdma_pkg::sts_t                  sts,
	input  logic [jdma_pkg::STICK_W-1:0]    stick,
	input  logic [jdma_pkg::AXIS_W-1:0]     sample_x,
	input  logic [jdma_pkg::AXIS_W-1:0]     sample_y,
	output logic                            accepted,
	output logic [jdma_pkg::AXIS_W-1:0]     average_x,
	output logic [jdma_pkg::AXIS_W-1:0]     average_y
);

	localparam int AW = jdma_pkg::AXIS_W;
	localparam int SW = jdma_pkg::SUM_W;
	localparam int LW = jdma_pkg::LEN_W;
	localparam int PW = jdma_pkg::POS_W;

	// Captured item
	logic [jdma_pkg::STICK_W-1:0] stick_q;
	logic [AW-1:0]                x_q;
	logic [AW-1:0]                y_q;

	// Squared offsets
	logic [jdma_pkg::SQ_W-1:0]    sqx_q, sqy_q, sqr_q;
	logic                         hit_q;

	// Ring memories and their valid bits
	logic [AW-1:0]                ring_x_mem [jdma_pkg::RING_DEPTH];
	logic [AW-1:0]                ring_y_mem [jdma_pkg::RING_DEPTH];
	logic [jdma_pkg::RING_DEPTH-1:0] ring_vld_q;
	logic [AW-1:0]                rd_x_q, rd_y_q;
	logic                         rd_vld_q;

	// Per-stick state
	logic [SW-1:0]                sum_x_q [jdma_pkg::STICKS];
	logic [SW-1:0]                sum_y_q [jdma_pkg::STICKS];
	logic [PW-1:0]                pos_q   [jdma_pkg::STICKS];
	logic [AW-1:0]                held_x_q [jdma_pkg::STICKS];
	logic [AW-1:0]                held_y_q [jdma_pkg::STICKS];

	// Dividers: dividend shifts into quotient
	logic [SW-1:0]                dvd_x_q, dvd_y_q;
	logic [LW:0]                  rem_x_q, rem_y_q;

	// Output register
	logic                         out_acc_q;
	logic [AW-1:0]                out_x_q, out_y_q;

	logic                         present;
	logic [AW-1:0]                rest_x, rest_y, dx, dy;
	logic [LW-1:0]                len;
	logic [PW-1:0]                pos;
	logic [PW:0]                  pos_inc;
	logic [PW-1:0]                pos_nxt;
	logic [jdma_pkg::RING_AW-1:0] addr;
	logic [AW-1:0]                old_x, old_y;
	logic [SW-1:0]                new_sum_x, new_sum_y;
	logic [LW:0]                  shx, shy;
	logic                         qx, qy;
	logic [AW-1:0]                sat_x, sat_y;
	logic                         hit;

	assign present = (32'(stick_q) < jdma_pkg::STICKS);
	assign rest_x  = (stick_q == 1'b0) ? cfg.rest_x_first : cfg.rest_x_second;
	assign rest_y  = (stick_q == 1'b0) ? cfg.rest_y_first : cfg.rest_y_second;
	assign dx      = (x_q >= rest_x) ? (x_q - rest_x) : (rest_x - x_q);
	assign dy      = (y_q >= rest_y) ? (y_q - rest_y) : (rest_y - y_q);

	// Clamp the window length into 1..WINDOW_MAX
	always_comb begin
		if (cfg.window_length == '0) begin
			len = LW'(1);
		end else if (32'(cfg.window_length) > jdma_pkg::WINDOW_MAX) begin
			len = LW'(jdma_pkg::WINDOW_MAX);
		end else begin
			len = LW'(cfg.window_length);
		end
	end

	// Ring slot and position advance
	assign pos     = pos_q[stick_q];
	assign addr    = jdma_pkg::RING_AW'(32'(stick_q) * jdma_pkg::WINDOW_MAX + 32'(pos));
	assign pos_inc = {1'b0, pos} + 1'b1;
	assign pos_nxt = (32'(pos_inc) >= 32'(len)) ? '0 : pos_inc[PW-1:0];

	// Old entry, zero when never written
	assign old_x     = rd_vld_q ? rd_x_q : '0;
	assign old_y     = rd_vld_q ? rd_y_q : '0;
	assign new_sum_x = sum_x_q[stick_q] - SW'(old_x) + SW'(x_q);
	assign new_sum_y = sum_y_q[stick_q] - SW'(old_y) + SW'(y_q);

	// Deadband test
	assign hit     = present &&
		(({1'b0, sqx_q} + {1'b0, sqy_q}) > {1'b0, sqr_q});
	assign sts.hit = hit;

	// Restoring divide step
	assign shx = {rem_x_q[LW-1:0], dvd_x_q[SW-1]};
	assign shy = {rem_y_q[LW-1:0], dvd_y_q[SW-1]};
	assign qx  = (shx >= {1'b0, len});
	assign qy  = (shy >= {1'b0, len});

	// Saturate the quotient to the axis range
	assign sat_x = (dvd_x_q > SW'(jdma_pkg::AXIS_MAX)) ? jdma_pkg::AXIS_MAX : dvd_x_q[AW-1:0];
	assign sat_y = (dvd_y_q > SW'(jdma_pkg::AXIS_MAX)) ? jdma_pkg::AXIS_MAX : dvd_y_q[AW-1:0];

	// Capture, squares, decision and divider payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stick_q <= stick;
			x_q     <= sample_x;
			y_q     <= sample_y;
		end
		if (cmd.square) begin
			sqx_q <= jdma_pkg::SQ_W'(dx) * jdma_pkg::SQ_W'(dx);
			sqy_q <= jdma_pkg::SQ_W'(dy) * jdma_pkg::SQ_W'(dy);
			sqr_q <= jdma_pkg::SQ_W'(cfg.deadband_radius) *
				jdma_pkg::SQ_W'(cfg.deadband_radius);
			rd_x_q   <= ring_x_mem[addr];
			rd_y_q   <= ring_y_mem[addr];
			rd_vld_q <= ring_vld_q[addr];
		end
		if (cmd.judge) begin
			hit_q <= hit;
		end
		if (cmd.update) begin
			ring_x_mem[addr] <= x_q;
			ring_y_mem[addr] <= y_q;
			dvd_x_q <= new_sum_x;
			dvd_y_q <= new_sum_y;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if (cmd.div_step) begin
			dvd_x_q <= {dvd_x_q[SW-2:0], qx};
			dvd_y_q <= {dvd_y_q[SW-2:0], qy};
			rem_x_q <= qx ? (shx - {1'b0, len}) : shx;
			rem_y_q <= qy ? (shy - {1'b0, len}) : shy;
		end
		if (cmd.out_load) begin
			out_acc_q <= hit_q;
			if (hit_q) begin
				out_x_q <= sat_x;
				out_y_q <= sat_y;
			end else if (present) begin
				out_x_q <= held_x_q[stick_q];
				out_y_q <= held_y_q[stick_q];
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
			end
		end
	end

	// Filter state cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			for (int i = 0; i < jdma_pkg::STICKS; i++) begin
				sum_x_q[i]  <= '0;
				sum_y_q[i]  <= '0;
				pos_q[i]    <= '0;
				held_x_q[i] <= '0;
				held_y_q[i] <= '0;
			end
		end else begin
			if (cmd.update) begin
				ring_vld_q[addr]  <= 1'b1;
				sum_x_q[stick_q]  <= new_sum_x;
				sum_y_q[stick_q]  <= new_sum_y;
				pos_q[stick_q]    <= pos_nxt;
			end
			if (cmd.out_load && hit_q) begin
				held_x_q[stick_q] <= sat_x;
				held_y_q[stick_q] <= sat_y;
			end
		end
	end

	assign accepted  = out_acc_q;
	assign average_x = out_x_q;
	assign average_y = out_y_q;

endmodule

### hw/rtl/joystick_deadband_moving_average.sv
// Joystick moving average with a radial deadband.
// Input channel s_*: one sample pair per item, tuser selects the joystick.
// Output channel m_*: one result per input item, in order; tuser is the accepted
// flag, tdata the held X/Y averages of that joystick.
// APB port: six registers at byte addresses 0..20 (rest positions, deadband
// radius, window length); write only while the block is idle.
// Timing: items are handled one at a time; the next item enters after the
// result of the previous one is loaded. A sample inside the deadband passes the
// square, judge and finish states. A sample outside it also passes the update
// state and the restoring divider (one quotient bit per cycle per axis, both
// axes together), which runs one step per bit of the window sum.
// Stall: the result sits in an output register; the next item is accepted and
// processed while it waits, and its own result holds in the final state until
// the output register is taken.
// Reset (arst_n low): registers return to their defaults, rings, sums, ring
// positions and held averages read as zero, no result is pending.
module joystick_deadband_moving_average (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [jdma_pkg::PADDR_W-1:0]     paddr,
	input  logic [jdma_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [jdma_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	// Input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [jdma_pkg::DATA_W-1:0]      s_tdata,  // sample_x[9:0], sample_y[19:10], zero pad
	input  logic [jdma_pkg::STICK_W-1:0]     s_tuser,  // stick
	// Result items
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [jdma_pkg::DATA_W-1:0]      m_tdata,  // average_x[9:0], average_y[19:10], zero pad
	output logic                             m_tuser   // accepted
);

	localparam int AW = jdma_pkg::AXIS_W;

	jdma_pkg::cfg_t cfg;
	jdma_pkg::cmd_t cmd;
	jdma_pkg::sts_t sts;
	logic [AW-1:0]  average_x, average_y;

	jdma_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jdma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	jdma_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.stick     (s_tuser),
		.sample_x  (s_tdata[AW-1:0]),
		.sample_y  (s_tdata[2*AW-1:AW]),
		.accepted  (m_tuser),
		.average_x (average_x),
		.average_y (average_y)
	);

	assign m_tdata = {(jdma_pkg::DATA_W - 2 * AW)'(0), average_y, average_x};

	// One item in flight: input closes right after an acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// An accepted item's result does not appear while it is still being squared or judged
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##1 !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result produced before the deadband test completed");

	// Output register is never reloaded while a result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("stalled result dropped");

endmodule

### sim/tb_joystick_deadband_moving_average.sv
module tb_joystick_deadband_moving_average;
	timeunit 1ns;
	timeprecision 1ps;

	import jdma_pkg::*;

	// One result item as the block reports it
	typedef struct packed {
		logic              accepted;
		logic [AXIS_W-1:0] avg_x;
		logic [AXIS_W-1:0] avg_y;
	} filter_out_t;

	// One row of the directed part: a register write or a sample pair
	typedef struct packed {
		bit                    is_write;
		logic [REG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  stick;
		logic [AXIS_W-1:0]     sx;
		logic [AXIS_W-1:0]     sy;
		bit                    typed;
		filter_out_t           want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;  // sample_x[9:0], sample_y[19:10], zero pad
	logic [STICK_W-1:0]    s_tuser;  // stick
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;  // average_x[9:0], average_y[19:10], zero pad
	logic                  m_tuser;  // accepted

	// Filter state mirrored by the testbench
	cfg_t              knobs;
	logic [AXIS_W-1:0] hist_x [RING_DEPTH];
	logic [AXIS_W-1:0] hist_y [RING_DEPTH];
	logic [SUM_W-1:0]  total_x [STICKS];
	logic [SUM_W-1:0]  total_y [STICKS];
	logic [POS_W-1:0]  slot_idx [STICKS];
	logic [AXIS_W-1:0] mean_x [STICKS];
	logic [AXIS_W-1:0] mean_y [STICKS];

	filter_out_t pending_averages [$];
	plan_row_t   plan [$];
	int          errors = 0;
	bit          send_gaps = 1'b1;
	bit          recv_gaps = 1'b1;
	bit          hold_request = 1'b0;

	joystick_deadband_moving_average dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bound the run
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	// Clear the mirrored state to its reset contents
	function automatic void clear_filter();
		knobs.rest_x_first    = REST_RESET;
		knobs.rest_y_first    = REST_RESET;
		knobs.rest_x_second   = REST_RESET;
		knobs.rest_y_second   = REST_RESET;
		knobs.deadband_radius = RADIUS_RESET;
		knobs.window_length   = WINDOW_RESET;
		for (int i = 0; i < RING_DEPTH; i++) begin
			hist_x[i] = '0;
			hist_y[i] = '0;
		end
		for (int s = 0; s < STICKS; s++) begin
			total_x[s]  = '0;
			total_y[s]  = '0;
			slot_idx[s] = '0;
			mean_x[s]   = '0;
			mean_y[s]   = '0;
		end
	endfunction

	// Apply one sample pair to the mirrored filter and return its result
	function automatic filter_out_t filter_sample(input logic stick, input logic [AXIS_W-1:0] sx,
			input logic [AXIS_W-1:0] sy);
		filter_out_t r;
		int s, dx, dy, dist2, rad2, len, pos, slot, qx, qy;
		s = int'(stick);
		dx = int'(sx) - int'(s ? knobs.rest_x_second : knobs.rest_x_first);
		dy = int'(sy) - int'(s ? knobs.rest_y_second : knobs.rest_y_first);
		dist2 = dx * dx + dy * dy;
		rad2 = int'(knobs.deadband_radius) * int'(knobs.deadband_radius);
		len = int'(knobs.window_length);
		if (len == 0)
			len = 1;
		if (len > WINDOW_MAX)
			len = WINDOW_MAX;
		r.accepted = (dist2 > rad2);
		if (r.accepted) begin
			// Replace the slot under the ring index; the sum spans the whole ring
			pos = int'(slot_idx[s]) % WINDOW_MAX;
			slot = s * WINDOW_MAX + pos;
			total_x[s] = SUM_W'(int'(total_x[s]) - int'(hist_x[slot]) + int'(sx));
			total_y[s] = SUM_W'(int'(total_y[s]) - int'(hist_y[slot]) + int'(sy));
			hist_x[slot] = sx;
			hist_y[slot] = sy;
			pos = pos + 1;
			if (pos >= len)
				pos = 0;
			slot_idx[s] = POS_W'(pos);
			// Divide and clip to the axis range
			qx = int'(total_x[s]) / len;
			qy = int'(total_y[s]) / len;
			mean_x[s] = (qx > AXIS_TOP) ? AXIS_MAX : AXIS_W'(qx);
			mean_y[s] = (qy > AXIS_TOP) ? AXIS_MAX : AXIS_W'(qy);
		end
		r.avg_x = mean_x[s];
		r.avg_y = mean_y[s];
		return r;
	endfunction

	function automatic plan_row_t write_row(input logic [REG_IDX_W-1:0] idx, input int val);
		plan_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_val = CFG_DATA_W'(val);
		return row;
	endfunction

	function automatic plan_row_t sample_row(input logic stick, input int x, input int y);
		plan_row_t row;
		row = '0;
		row.stick = stick;
		row.sx = AXIS_W'(x);
		row.sy = AXIS_W'(y);
		return row;
	endfunction

	function automatic plan_row_t checked_row(input logic stick, input int x, input int y,
			input logic acc, input int ex, input int ey);
		plan_row_t row;
		row = sample_row(stick, x, y);
		row.typed = 1'b1;
		row.want.accepted = acc;
		row.want.avg_x = AXIS_W'(ex);
		row.want.avg_y = AXIS_W'(ey);
		return row;
	endfunction

	// Pick one axis reading: extremes, near the rest position, or anywhere
	function automatic logic [AXIS_W-1:0] pick_axis(input logic [AXIS_W-1:0] rest);
		int draw, span, v;
		draw = $urandom_range(0, 19);
		if (draw < 3)
			return $urandom_range(0, 1) ? AXIS_MAX : '0;
		if (draw < 11) begin
			span = int'(knobs.deadband_radius) + 3;
			v = int'(rest) + int'($urandom_range(0, 2 * span)) - span;
			if (v < 0)
				v = 0;
			if (v > AXIS_TOP)
				v = AXIS_TOP;
			return AXIS_W'(v);
		end
		return AXIS_W'($urandom_range(0, AXIS_TOP));
	endfunction

	function automatic int pick_rest();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return AXIS_TOP;
			default: return $urandom_range(0, AXIS_TOP);
		endcase
	endfunction

	// Write one register over APB; stray upper bits must be ignored
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int val);
		logic [CFG_DATA_W-1:0] mask, word;
		mask = (idx == REG_WINDOW) ? CFG_DATA_W'((1 << WIN_REG_W) - 1) : CFG_DATA_W'(AXIS_TOP);
		word = CFG_DATA_W'(val) & mask;
		if ($urandom_range(0, 3) == 0)
			word = word | ($urandom & ~mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << 2;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_REST_X_FIRST:  knobs.rest_x_first    = word[AXIS_W-1:0];
			REG_REST_Y_FIRST:  knobs.rest_y_first    = word[AXIS_W-1:0];
			REG_REST_X_SECOND: knobs.rest_x_second   = word[AXIS_W-1:0];
			REG_REST_Y_SECOND: knobs.rest_y_second   = word[AXIS_W-1:0];
			REG_DEADBAND:      knobs.deadband_radius = word[AXIS_W-1:0];
			REG_WINDOW:        knobs.window_length   = word[WIN_REG_W-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and hold until every expected result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Offer one sample pair and record its expected result on acceptance
	task automatic send_item(input logic stick, input logic [AXIS_W-1:0] sx,
			input logic [AXIS_W-1:0] sy, input bit typed, input filter_out_t want);
		int gap;
		filter_out_t model_out;
		gap = send_gaps ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(DATA_W - 2 * AXIS_W){1'b0}}, sy, sx};
		s_tuser  <= stick;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model_out = filter_sample(stick, sx, sy);
		pending_averages.push_back(typed ? want : model_out);
	endtask

	// Compare one result item with the oldest expectation
	task automatic check_result(input logic acc, input logic [DATA_W-1:0] data);
		filter_out_t want;
		if (pending_averages.size() == 0) begin
			$error("result item with no expectation: accepted %0d data %h", acc, data);
			errors++;
		end else begin
			want = pending_averages.pop_front();
			if (acc !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, acc);
				errors++;
			end
			if (data[AXIS_W-1:0] !== want.avg_x) begin
				$error("average_x: expected %0d, got %0d", want.avg_x, data[AXIS_W-1:0]);
				errors++;
			end
			if (data[2*AXIS_W-1:AXIS_W] !== want.avg_y) begin
				$error("average_y: expected %0d, got %0d", want.avg_y, data[2*AXIS_W-1:AXIS_W]);
				errors++;
			end
		end
	endtask

	// Result side: random ready gaps, one long hold on request
	initial begin : result_side
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = recv_gaps ? $urandom_range(0, 13) : 0;
			if (hold_request) begin
				hold_request = 1'b0;
				gap = 300;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			check_result(m_tuser, m_tdata);
		end
	end

	// Sample side: reset, directed table, random phases, wind-down
	initial begin : sample_side
		int sent, phase, n;
		logic st;
		plan_row_t row;
		filter_out_t none;
		none = '0;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		clear_filter();

		// Defaults after reset, the deadband edge, first averages
		plan.push_back(checked_row(1'b0, 512, 512, 1'b0, 0, 0));
		plan.push_back(checked_row(1'b0, 537, 512, 1'b0, 0, 0));
		plan.push_back(checked_row(1'b0, 538, 512, 1'b1, 33, 32));
		plan.push_back(checked_row(1'b1, 1023, 1023, 1'b1, 63, 63));
		plan.push_back(checked_row(1'b1, 0, 0, 1'b1, 63, 63));
		plan.push_back(sample_row(1'b0, 0, 1023));
		// Shrink the window under a live ring index; averages saturate
		plan.push_back(write_row(REG_WINDOW, 1));
		plan.push_back(sample_row(1'b0, 1023, 0));
		plan.push_back(sample_row(1'b1, 700, 300));
		plan.push_back(sample_row(1'b0, 1023, 1023));
		// A zero window acts as one
		plan.push_back(write_row(REG_WINDOW, 0));
		plan.push_back(sample_row(1'b0, 200, 800));
		// Zero radius: only the rest position itself is ignored
		plan.push_back(write_row(REG_DEADBAND, 0));
		plan.push_back(sample_row(1'b1, 512, 512));
		plan.push_back(sample_row(1'b1, 513, 512));
		// Rest positions in the corners, widest radius, oversized window
		plan.push_back(write_row(REG_REST_X_FIRST, 0));
		plan.push_back(write_row(REG_REST_Y_FIRST, AXIS_TOP));
		plan.push_back(write_row(REG_REST_X_SECOND, AXIS_TOP));
		plan.push_back(write_row(REG_REST_Y_SECOND, 0));
		plan.push_back(write_row(REG_DEADBAND, AXIS_TOP));
		plan.push_back(write_row(REG_WINDOW, 31));
		plan.push_back(sample_row(1'b0, 1023, 0));
		plan.push_back(sample_row(1'b0, 1023, 1023));
		plan.push_back(sample_row(1'b1, 0, 1023));
		plan.push_back(sample_row(1'b1, 0, 0));
		plan.push_back(sample_row(1'b0, 0, 1023));
		// Back to the defaults
		plan.push_back(write_row(REG_WINDOW, 16));
		plan.push_back(write_row(REG_DEADBAND, 25));
		plan.push_back(write_row(REG_REST_X_FIRST, 512));
		plan.push_back(write_row(REG_REST_Y_FIRST, 512));
		plan.push_back(write_row(REG_REST_X_SECOND, 512));
		plan.push_back(write_row(REG_REST_Y_SECOND, 512));
		plan.push_back(sample_row(1'b0, 1023, 1023));
		plan.push_back(sample_row(1'b1, 0, 1023));
		plan.push_back(sample_row(1'b0, 487, 512));
		plan.push_back(sample_row(1'b0, 512, 486));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_write) begin
				drain_results();
				apb_write(row.reg_idx, int'(row.reg_val));
			end else begin
				send_item(row.stick, row.sx, row.sy, row.typed, row.want);
			end
		end

		// Random phases, each under a fresh register setting
		sent = 0;
		phase = 0;
		while (sent < 1800) begin
			drain_results();
			apb_write(REG_REST_X_FIRST, pick_rest());
			apb_write(REG_REST_Y_FIRST, pick_rest());
			apb_write(REG_REST_X_SECOND, pick_rest());
			apb_write(REG_REST_Y_SECOND, pick_rest());
			case ($urandom_range(0, 5))
				0: apb_write(REG_DEADBAND, 0);
				1: apb_write(REG_DEADBAND, AXIS_TOP);
				2, 3: apb_write(REG_DEADBAND, $urandom_range(0, 60));
				default: apb_write(REG_DEADBAND, $urandom_range(0, 400));
			endcase
			case ($urandom_range(0, 7))
				0: apb_write(REG_WINDOW, 0);
				1: apb_write(REG_WINDOW, 1);
				2: apb_write(REG_WINDOW, WINDOW_MAX);
				3: apb_write(REG_WINDOW, $urandom_range(WINDOW_MAX + 1, 31));
				default: apb_write(REG_WINDOW, $urandom_range(1, WINDOW_MAX));
			endcase
			send_gaps = ($urandom_range(0, 3) != 0);
			recv_gaps = ($urandom_range(0, 3) != 0);
			n = $urandom_range(80, 220);
			for (int i = 0; i < n; i++) begin
				// Stall the result side while samples keep coming
				if ((phase == 2 || phase == 6) && i == 40)
					hold_request = 1'b1;
				st = $urandom_range(0, 1);
				send_item(st, pick_axis(st ? knobs.rest_x_second : knobs.rest_x_first),
					pick_axis(st ? knobs.rest_y_second : knobs.rest_y_first), 1'b0, none);
			end
			sent += n;
			phase++;
		end

		// Wind down and report
		drain_results();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
